// ----- rtl/core/atrc_pkg.sv -----
`default_nettype none

package atrc_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 4096;
  localparam int QUEUE_DEPTH          = 2;
  localparam int LEN_W                = 13;
  localparam int IDX_W                = 12;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_O  = 8'h4F;
  localparam logic [7:0] CH_K  = 8'h4B;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_R  = 8'h52;

  typedef enum logic [1:0] {
    OP_ARM  = 2'd0,
    OP_BYTE = 2'd1,
    OP_TICK = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERROR = 2'd1,
    ST_FAIL  = 2'd2
  } st_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [7:0]       rx_byte;
    logic [15:0]      timeout_ticks;
    logic [IDX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic             busy_res;
    logic [1:0]       status;
    logic             finished;
    logic [LEN_W-1:0] received_length;
    logic [7:0]       read_data;
  } out_item_t;

  typedef struct packed {
    logic push;
  } q_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/atrc_ram.sv -----
`default_nettype none

module atrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/atrc_queue.sv -----
`default_nettype none

module atrc_queue
  import atrc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_ctrl_t   ctrl_in,
  output logic           full,
  input  wire out_item_t push_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  out_item_t       entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_data  = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (ctrl_in.push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (ctrl_in.push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !ctrl_in.push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_in.push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/atrc_front.sv -----
`default_nettype none

module atrc_front
  import atrc_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire in_item_t                        in_data,
  output logic                                 mem_we,
  output logic [$clog2(BUFFER_DEPTH)-1:0]      mem_waddr,
  output logic [7:0]                           mem_wdata,
  output logic                                 mem_re,
  output logic [$clog2(BUFFER_DEPTH)-1:0]      mem_raddr,
  input  wire logic [7:0]                      mem_rdata,
  output q_ctrl_t                              q_ctrl,
  input  wire logic                            q_full,
  output out_item_t                            push_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  logic             active_r, active_nxt;
  st_t              status_r, status_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [47:0]      recent_r, recent_nxt;
  logic [15:0]      ticks_r, ticks_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  out_item_t        s1_item_r;
  logic             s1_hit_r;

  op_t              op;
  logic             accept;
  logic             push;
  logic             fin;
  logic             buf_full;
  logic [CW-1:0]    count_inc;
  logic             ok_hit;
  logic             err_hit;
  logic [15:0]      ticks_dec;
  logic [XW-1:0]    idx_ext;
  logic             rd_hit;
  out_item_t        item;

  assign op        = op_t'(in_data.operation);
  assign push      = s1_valid_r && !q_full;
  assign in_ready  = !s1_valid_r || !q_full;
  assign accept    = in_valid && in_ready;
  assign buf_full  = (count_r == CW'(BUFFER_DEPTH));
  assign count_inc = count_r + CW'(1);
  assign idx_ext   = XW'(in_data.read_index);
  assign rd_hit    = (op == OP_READ) && (idx_ext < XW'(count_r));

  assign ok_hit = (in_data.rx_byte == CH_LF) && (recent_r[7:0] == CH_CR)
               && (recent_r[15:8] == CH_K) && (recent_r[23:16] == CH_O)
               && (count_inc >= CW'(4));
  assign err_hit = (in_data.rx_byte == CH_LF) && (recent_r[7:0] == CH_CR)
                && (recent_r[15:8] == CH_R) && (recent_r[23:16] == CH_O)
                && (recent_r[31:24] == CH_R) && (recent_r[39:32] == CH_R)
                && (recent_r[47:40] == CH_E) && (count_inc >= CW'(7));

  assign mem_we    = accept && (op == OP_BYTE) && active_r && !buf_full;
  assign mem_waddr = count_r[AW-1:0];
  assign mem_wdata = in_data.rx_byte;
  assign mem_re    = accept && (op == OP_READ);
  assign mem_raddr = idx_ext[AW-1:0];

  always_comb begin
    active_nxt = active_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    recent_nxt = recent_r;
    ticks_nxt  = ticks_r;
    ticks_dec  = ticks_r;
    fin        = 1'b0;
    unique case (op)
      OP_ARM: begin
        count_nxt  = '0;
        recent_nxt = '0;
        status_nxt = ST_FAIL;
        ticks_nxt  = in_data.timeout_ticks;
        if (in_data.timeout_ticks == 16'd0) begin
          active_nxt = 1'b0;
          fin        = 1'b1;
        end else begin
          active_nxt = 1'b1;
        end
      end
      OP_BYTE: begin
        if (active_r) begin
          if (!buf_full) begin
            count_nxt  = count_inc;
            recent_nxt = {recent_r[39:0], in_data.rx_byte};
            if (ok_hit) begin
              status_nxt = ST_OK;
              active_nxt = 1'b0;
              fin        = 1'b1;
            end else if (err_hit) begin
              status_nxt = ST_ERROR;
              active_nxt = 1'b0;
              fin        = 1'b1;
            end
          end else begin
            status_nxt = ST_FAIL;
            active_nxt = 1'b0;
            fin        = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (active_r) begin
          ticks_dec = (ticks_r != 16'd0) ? ticks_r - 16'd1 : ticks_r;
          ticks_nxt = ticks_dec;
          if (ticks_dec == 16'd0) begin
            active_nxt = 1'b0;
            fin        = 1'b1;
          end
        end
      end
      OP_READ: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    item                 = '0;
    item.busy_res        = active_nxt;
    item.status          = status_nxt;
    item.finished        = fin;
    item.received_length = LEN_W'(count_nxt);
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      status_r   <= ST_FAIL;
      count_r    <= '0;
      recent_r   <= '0;
      ticks_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        active_r <= active_nxt;
        status_r <= status_nxt;
        count_r  <= count_nxt;
        recent_r <= recent_nxt;
        ticks_r  <= ticks_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= item;
      s1_hit_r  <= rd_hit;
    end
  end

  // read data lines up with the stage register: the RAM only reads on accept
  always_comb begin
    push_data           = s1_item_r;
    push_data.read_data = s1_hit_r ? mem_rdata : 8'h00;
  end

  assign q_ctrl.push = push;

endmodule

`default_nettype wire

// ----- rtl/core/at_response_capture.sv -----
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_ready  in_data   (in_item_t)
// out      output     out_valid/out_ready out_data (out_item_t)
//
// One transaction per cycle sustained while the result port keeps up; a result
// passes through the classify stage register and then the queue entry.
// A two-entry queue parts the classify stage from the result port.
// Reset is synchronous (rst_n low); the response buffer is not cleared.
// A stalled result port fills the queue and the stage, then holds in_ready low.
`default_nettype none

module at_response_capture
  import atrc_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  q_ctrl_t       q_ctrl;
  logic          q_full;
  out_item_t     push_data;

  atrc_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  atrc_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .q_ctrl    (q_ctrl),
    .q_full    (q_full),
    .push_data (push_data)
  );

  atrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl_in   (q_ctrl),
    .full      (q_full),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctrl.push |-> !q_full)
    else $error("queue push while full");

  a_fin_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.finished) |-> !out_data.busy_res)
    else $error("finished result still busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_ERROR
                   || out_data.status == ST_FAIL))
    else $error("bad status code");

  a_busy_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.busy_res) |-> (out_data.status == ST_FAIL))
    else $error("active capture with final status");

endmodule

`default_nettype wire

// ----- test/response_capture_checker.sv -----
`timescale 1ns / 1ps

module response_capture_checker
  import atrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        err_count,
  output int        pending_count
);

  localparam int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH;

  logic [7:0]       resp_buf [BUFFER_DEPTH];
  logic [LEN_W-1:0] stored_len  = '0;
  logic             capturing   = 1'b0;
  logic [1:0]       cap_status  = ST_FAIL;
  logic [47:0]      history     = '0;
  logic [15:0]      ticks_left  = '0;

  out_item_t expected_results [$];
  out_item_t want;
  int        errors = 0;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  function automatic out_item_t capture_step(input in_item_t t);
    out_item_t r;
    logic      ok_tail;
    logic      err_tail;
    r = '0;
    case (t.operation)
      OP_ARM: begin
        stored_len = '0;
        history    = '0;
        cap_status = ST_FAIL;
        ticks_left = t.timeout_ticks;
        capturing  = 1'b1;
        if (t.timeout_ticks == 16'd0) begin
          capturing  = 1'b0;
          r.finished = 1'b1;
        end
      end
      OP_BYTE: begin
        if (capturing) begin
          if (stored_len < BUFFER_DEPTH) begin
            resp_buf[stored_len[IDX_W-1:0]] = t.rx_byte;
            stored_len = stored_len + 1'b1;
            ok_tail  = (t.rx_byte == CH_LF) && (stored_len >= 4) &&
                       (history[23:0] == {CH_O, CH_K, CH_CR});
            err_tail = (t.rx_byte == CH_LF) && (stored_len >= 7) &&
                       (history == {CH_E, CH_R, CH_R, CH_O, CH_R, CH_CR});
            if (ok_tail) begin
              cap_status = ST_OK;
              capturing  = 1'b0;
              r.finished = 1'b1;
            end else if (err_tail) begin
              cap_status = ST_ERROR;
              capturing  = 1'b0;
              r.finished = 1'b1;
            end
            history = {history[39:0], t.rx_byte};
          end else begin
            // buffer full
            cap_status = ST_FAIL;
            capturing  = 1'b0;
            r.finished = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (capturing) begin
          if (ticks_left != 16'd0) ticks_left = ticks_left - 1'b1;
          if (ticks_left == 16'd0) begin
            capturing  = 1'b0;
            r.finished = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (t.read_index < stored_len) r.read_data = resp_buf[t.read_index];
      end
    endcase
    r.busy_res        = capturing;
    r.status          = cap_status;
    r.received_length = stored_len;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) expected_results.push_back(capture_step(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_data.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res got %0d exp %0d",
                                      out_data.busy_res, want.busy_res));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d exp %0d",
                                      out_data.status, want.status));
          if (out_data.finished !== want.finished)
            report_mismatch($sformatf("finished got %0d exp %0d",
                                      out_data.finished, want.finished));
          if (out_data.received_length !== want.received_length)
            report_mismatch($sformatf("received_length got %0d exp %0d",
                                      out_data.received_length, want.received_length));
          if (out_data.read_data !== want.read_data)
            report_mismatch($sformatf("read_data got %0h exp %0h",
                                      out_data.read_data, want.read_data));
        end
      end
    end
    pending_count <= expected_results.size();
    err_count     <= errors;
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import atrc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic      clk       = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int send_idle_pct = 15;
  int recv_idle_pct = 86;
  int items_sent    = 0;
  int resp_len      = 0;
  int cycle_count   = 0;
  int err_count;
  int pending_count;

  always #6 clk = ~clk;

  at_response_capture i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  response_capture_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .err_count     (err_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_txn(input in_item_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic in_item_t rand_item(input op_t op);
    in_item_t t;
    t.operation     = op;
    t.rx_byte       = 8'($urandom);
    t.timeout_ticks = 16'($urandom);
    t.read_index    = 12'($urandom);
    return t;
  endfunction

  task automatic send_arm(input logic [15:0] budget);
    in_item_t t;
    t = rand_item(OP_ARM);
    t.timeout_ticks = budget;
    resp_len = 0;
    send_txn(t);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t t;
    t = rand_item(OP_BYTE);
    t.rx_byte = b;
    resp_len++;
    send_txn(t);
  endtask

  task automatic send_tick();
    send_txn(rand_item(OP_TICK));
  endtask

  task automatic send_read(input logic [11:0] idx);
    in_item_t t;
    t = rand_item(OP_READ);
    t.read_index = idx;
    send_txn(t);
  endtask

  task automatic send_terminator(input string word);
    for (int i = 0; i < word.len(); i++) send_byte(word[i]);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  function automatic logic [11:0] pick_index();
    if ($urandom_range(3) == 0) return 12'($urandom);
    return 12'($urandom_range(resp_len + 1));
  endfunction

  function automatic logic [7:0] filler_byte();
    case ($urandom_range(9))
      0:       return 8'($urandom);
      1:       return CH_CR;
      2:       return CH_LF;
      3:       return CH_K;
      4:       return CH_R;
      default: return 8'($urandom_range(126, 32));
    endcase
  endfunction

  // hold off until the checker has nothing outstanding
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic run_random(input int count);
    int stop;
    int r;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(5, 1)) send_txn(rand_item(op_t'($urandom_range(3))));
      end else begin
        if ($urandom_range(7) == 0) send_arm(16'($urandom_range(4, 1)));
        else send_arm(16'($urandom_range(65535, 16)));
        repeat ($urandom_range(12)) begin
          r = $urandom_range(99);
          if (r < 5) send_tick();
          else if (r < 9) send_read(pick_index());
          else if (r < 10) send_arm(16'($urandom_range(65535, 1)));
          send_byte(filler_byte());
        end
        case ($urandom_range(5))
          0, 1:    send_terminator("OK");
          2, 3:    send_terminator("ERROR");
          4:       send_terminator("ERRO");
          default: ;
        endcase
        repeat ($urandom_range(2)) send_read(pick_index());
      end
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle bytes and ticks, zero and full budgets, both terminators,
    // reads in and out of range, budget expiry, re-arm while capturing
    send_read(12'd0);
    send_byte(8'hFF);
    send_tick();
    send_arm(16'd0);
    send_arm(16'hFFFF);
    send_terminator("OK");
    send_read(12'd0);
    send_read(12'd3);
    send_read(12'd4);
    send_read(12'hFFF);
    send_arm(16'hFFFF);
    send_terminator("ERROR");
    send_arm(16'd2);
    send_byte(8'h00);
    send_tick();
    send_arm(16'd1);
    send_tick();
    send_read(12'd0);

    run_random(300);
    drain();

    send_idle_pct = 86;
    recv_idle_pct <= 15;
    run_random(300);
    drain();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(300);
    drain();

    repeat (10) @(posedge clk);
    if (err_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/atrc_pkg.sv
rtl/core/atrc_ram.sv
rtl/core/atrc_queue.sv
rtl/core/atrc_front.sv
rtl/core/at_response_capture.sv
test/response_capture_checker.sv
test/tb.sv
